// ===== rtl/core/csi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSI sequence decoder package
// Shared byte codes, command codes and the parameter and result words.
// ----------------------------------------------------------------------------
package csi_pkg;

  localparam int PARAM_BITS = 16;
  localparam logic [PARAM_BITS-1:0] PARAM_MAX = '1;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_QMARK = 8'h3F;

  localparam logic [7:0] FIN_CUU = 8'h41;  // A
  localparam logic [7:0] FIN_CUD = 8'h42;  // B
  localparam logic [7:0] FIN_CUF = 8'h43;  // C
  localparam logic [7:0] FIN_CUB = 8'h44;  // D
  localparam logic [7:0] FIN_CNL = 8'h45;  // E
  localparam logic [7:0] FIN_CPL = 8'h46;  // F
  localparam logic [7:0] FIN_CHA = 8'h47;  // G
  localparam logic [7:0] FIN_CUP = 8'h48;  // H
  localparam logic [7:0] FIN_ED  = 8'h4A;  // J
  localparam logic [7:0] FIN_EL  = 8'h4B;  // K
  localparam logic [7:0] FIN_SU  = 8'h53;  // S
  localparam logic [7:0] FIN_SD  = 8'h54;  // T
  localparam logic [7:0] FIN_VPA = 8'h64;  // d
  localparam logic [7:0] FIN_HVP = 8'h66;  // f
  localparam logic [7:0] FIN_STBM = 8'h72; // r
  localparam logic [7:0] FIN_SCP = 8'h73;  // s
  localparam logic [7:0] FIN_RCP = 8'h75;  // u

  typedef enum logic [3:0] {
    OP_MOVE       = 4'd0,
    OP_SET_COL    = 4'd1,
    OP_SET_POS    = 4'd2,
    OP_SET_ROW    = 4'd3,
    OP_ERASE_DISP = 4'd4,
    OP_ERASE_LINE = 4'd5,
    OP_SCROLL_UP  = 4'd6,
    OP_SCROLL_DN  = 4'd7,
    OP_SET_REGION = 4'd8,
    OP_RST_REGION = 4'd9,
    OP_SAVE       = 4'd10,
    OP_RESTORE    = 4'd11
  } op_t;

  typedef struct packed {
    logic [PARAM_BITS-1:0] first;
    logic [PARAM_BITS-1:0] second;
    logic [1:0]            count;
    logic                  priv;
  } csi_params_t;

  typedef struct packed {
    logic                 col_home;
    logic [15:0]          amount;
    logic signed [16:0]   col_value;
    logic signed [16:0]   row_value;
    op_t                  op;
  } csi_result_t;

endpackage

// ===== rtl/core/csi_sequence_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSI sequence decoder
// Decodes CSI control sequence bytes into cursor, erase and scroll commands.
// ----------------------------------------------------------------------------
// Bytes after the CSI introducer enter on the s_ side, one word per cycle at
// full rate while the m_ side does not stall. Each byte is registered, parsed
// against the running sequence state and, on a final byte that names a supported
// command, a 56-bit command word is written to the output register. Bytes that
// only extend the sequence, private sequences and unsupported finals give no
// output word. The m_ side may stall; the input register keeps accepting while
// the output register is empty or being taken. The user must write screen_rows
// (reset 24) via cfg_we/cfg_wdata while the block is idle, which it does not enforce.
module csi_sequence_decoder import csi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,    // screen_rows
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,      // seq_byte[7:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata       // op[3:0], row_value[20:4], col_value[37:21],
                                    // amount[53:38], col_home[54], zero[55]
);

  logic [15:0]  screen_rows;
  logic         in_valid;
  logic [7:0]   in_byte;
  logic         out_valid;
  csi_result_t  out_data;

  logic         advance;
  logic         step;
  logic         is_final;
  logic         res_valid;
  csi_params_t  final_params;
  csi_result_t  result;

  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;
  assign step     = in_valid && advance;

  csi_seq_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .seq_byte     (in_byte),
    .is_final     (is_final),
    .final_params (final_params)
  );

  csi_seq_decode u_decode (
    .seq_byte    (in_byte),
    .params      (final_params),
    .screen_rows (screen_rows),
    .res_valid   (res_valid),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_rows <= 16'd24;
    end else if (cfg_we) begin
      screen_rows <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      in_byte <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step && is_final && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_data};

  a_op_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[3:0] <= OP_RESTORE))
    else $error("command code out of range");

  a_cr_move: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[54]) |-> (m_tdata[3:0] == OP_MOVE))
    else $error("carriage return on a non-move command");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && out_valid && !m_tready) |-> !s_tready)
    else $error("input taken while both stages are full and stalled");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (in_valid && out_valid && !m_tready) |=> (in_valid && $stable(in_byte)))
    else $error("buffered byte lost during output stall");

endmodule

// ===== rtl/core/csi_seq_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSI sequence parser
// Holds the running sequence state and presents the closing parameters.
// ----------------------------------------------------------------------------
module csi_seq_parser import csi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  seq_byte,
  output logic        is_final,
  output csi_params_t final_params
);

  logic [PARAM_BITS-1:0] first_param;
  logic [PARAM_BITS-1:0] second_param;
  logic [1:0]            param_count;
  logic [PARAM_BITS-1:0] digit_accumulator;
  logic                  digits_pending;
  logic                  last_was_semicolon;
  logic                  sequence_started;
  logic                  private_marker;

  logic                  is_marker;
  logic                  is_digit;
  logic                  is_sep;
  logic                  do_push;
  logic [PARAM_BITS-1:0] push_val;
  logic [PARAM_BITS+3:0] acc_prod;
  logic [PARAM_BITS-1:0] acc_sat;
  logic [PARAM_BITS-1:0] first_push;
  logic [PARAM_BITS-1:0] second_push;
  logic [1:0]            count_push;

  always_comb begin
    is_marker = !sequence_started && (seq_byte inside {CH_QMARK, CH_GT, CH_EQ, CH_BANG});
    is_digit  = !is_marker && (seq_byte inside {[CH_ZERO:CH_NINE]});
    is_sep    = seq_byte inside {CH_SEMI, CH_COLON};
    is_final  = !(seq_byte inside {[CH_SPACE:CH_QMARK]});

    acc_prod = ({4'b0, digit_accumulator} << 3) + ({4'b0, digit_accumulator} << 1)
             + {{PARAM_BITS{1'b0}}, seq_byte[3:0]};
    acc_sat  = (acc_prod > {4'b0, PARAM_MAX}) ? PARAM_MAX : acc_prod[PARAM_BITS-1:0];

    do_push  = is_sep || (is_final && (digits_pending || last_was_semicolon));
    push_val = digits_pending ? digit_accumulator : '0;

    first_push  = (do_push && param_count == 2'd0) ? push_val : first_param;
    second_push = (do_push && param_count == 2'd1) ? push_val : second_param;
    count_push  = (do_push && param_count != 2'd3) ? param_count + 2'd1 : param_count;

    final_params.first  = first_push;
    final_params.second = second_push;
    final_params.count  = count_push;
    final_params.priv   = private_marker;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_param        <= '0;
      second_param       <= '0;
      param_count        <= '0;
      digit_accumulator  <= '0;
      digits_pending     <= 1'b0;
      last_was_semicolon <= 1'b0;
      sequence_started   <= 1'b0;
      private_marker     <= 1'b0;
    end else if (step) begin
      if (is_final) begin
        first_param        <= '0;
        second_param       <= '0;
        param_count        <= '0;
        digit_accumulator  <= '0;
        digits_pending     <= 1'b0;
        last_was_semicolon <= 1'b0;
        sequence_started   <= 1'b0;
        private_marker     <= 1'b0;
      end else begin
        sequence_started   <= 1'b1;
        last_was_semicolon <= is_sep && (seq_byte == CH_SEMI);
        if (is_marker) begin
          private_marker <= 1'b1;
        end
        if (is_digit) begin
          digit_accumulator <= acc_sat;
          digits_pending    <= 1'b1;
        end
        if (is_sep) begin
          first_param        <= first_push;
          second_param       <= second_push;
          param_count        <= count_push;
          digit_accumulator  <= '0;
          digits_pending     <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== rtl/core/csi_seq_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSI final byte decoder
// Maps the final byte and closing parameters to one command word.
// ----------------------------------------------------------------------------
module csi_seq_decode import csi_pkg::*; (
  input  logic [7:0]  seq_byte,
  input  csi_params_t params,
  input  logic [15:0] screen_rows,
  output logic        res_valid,
  output csi_result_t result
);

  logic        have0;
  logic        have1;
  logic [15:0] p0;
  logic [15:0] p1_one;
  logic [15:0] p1_rows;
  logic [16:0] p0_w;
  logic [16:0] p0_neg;
  logic [16:0] p0_m1;
  logic [16:0] p1_one_m1;
  logic [16:0] p1_rows_m1;

  always_comb begin
    have0      = params.count != 2'd0;
    have1      = params.count >= 2'd2;
    p0         = (have0 && params.first != '0) ? params.first : 16'd1;
    p1_one     = (have1 && params.second != '0) ? params.second : 16'd1;
    p1_rows    = (have1 && params.second != '0) ? params.second : screen_rows;
    p0_w       = {1'b0, p0};
    p0_neg     = 17'd0 - p0_w;
    p0_m1      = p0_w - 17'd1;
    p1_one_m1  = {1'b0, p1_one} - 17'd1;
    p1_rows_m1 = {1'b0, p1_rows} - 17'd1;

    result    = '0;
    result.op = OP_MOVE;
    res_valid = 1'b1;
    case (seq_byte)
      FIN_CUU: result.row_value = p0_neg;
      FIN_CUD: result.row_value = p0_w;
      FIN_CUF: result.col_value = p0_w;
      FIN_CUB: result.col_value = p0_neg;
      FIN_CNL: begin
        result.row_value = p0_w;
        result.col_home  = 1'b1;
      end
      FIN_CPL: begin
        result.row_value = p0_neg;
        result.col_home  = 1'b1;
      end
      FIN_CHA: begin
        result.op        = OP_SET_COL;
        result.col_value = p0_m1;
      end
      FIN_CUP, FIN_HVP: begin
        result.op        = OP_SET_POS;
        result.row_value = p0_m1;
        result.col_value = p1_one_m1;
      end
      FIN_ED: begin
        result.op     = OP_ERASE_DISP;
        result.amount = have0 ? params.first : '0;
      end
      FIN_EL: begin
        result.op     = OP_ERASE_LINE;
        result.amount = have0 ? params.first : '0;
      end
      FIN_SU: begin
        result.op     = OP_SCROLL_UP;
        result.amount = p0;
      end
      FIN_SD: begin
        result.op     = OP_SCROLL_DN;
        result.amount = p0;
      end
      FIN_VPA: begin
        result.op        = OP_SET_ROW;
        result.row_value = p0_m1;
      end
      FIN_STBM: begin
        if (have0) begin
          result.op        = OP_SET_REGION;
          result.row_value = p0_m1;
          result.col_value = p1_rows_m1;
        end else begin
          result.op = OP_RST_REGION;
        end
      end
      FIN_SCP: result.op = OP_SAVE;
      FIN_RCP: result.op = OP_RESTORE;
      default: res_valid = 1'b0;
    endcase
    if (params.priv) begin
      res_valid = 1'b0;
    end
  end

endmodule

// ===== dv/tb_csi_sequence_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSI sequence decoder testbench
// Streams CSI sequence bytes into the decoder under random source and sink
// stalls, predicts each command word from its own copy of the parse state and
// checks every output word in order. Runs several screen_rows settings.
// ----------------------------------------------------------------------------
import csi_pkg::*;

class command_scoreboard;
  logic [15:0] rows;
  logic [15:0] first_p;
  logic [15:0] second_p;
  logic [15:0] acc;
  logic [1:0]  count;
  bit          digits_open;
  bit          semi;
  bit          started;
  bit          priv;
  csi_result_t pending_cmds[$];
  int          errors;
  int          cmds_checked;
  bit [11:0]   ops_seen;

  function new();
    rows = 16'd24;
    errors = 0;
    cmds_checked = 0;
    ops_seen = '0;
    clear_seq();
  endfunction

  function void clear_seq();
    first_p = '0;
    second_p = '0;
    acc = '0;
    count = '0;
    digits_open = 0;
    semi = 0;
    started = 0;
    priv = 0;
  endfunction

  function void push_param(logic [15:0] v);
    if (count == 2'd0) begin
      first_p = v;
    end else if (count == 2'd1) begin
      second_p = v;
    end
    if (count < 2'd3) begin
      count = count + 2'd1;
    end
  endfunction

  function int arg(int i, int dflt);
    logic [15:0] v;
    if (i >= int'(count) || i > 1) begin
      return dflt;
    end
    v = (i == 0) ? first_p : second_p;
    return (v == 16'd0) ? dflt : int'(v);
  endfunction

  function void queue_cmd(op_t op, int row, int col, int amt, bit cr);
    csi_result_t r;
    r.op = op;
    r.row_value = row[16:0];
    r.col_value = col[16:0];
    r.amount = amt[15:0];
    r.col_home = cr;
    pending_cmds = {pending_cmds, r};
  endfunction

  // Advance the parse state by one accepted byte.
  function void note_byte(logic [7:0] c);
    int v;
    int p;
    if (!started && (c == CH_QMARK || c == CH_GT || c == CH_EQ || c == CH_BANG)) begin
      priv = 1;
      started = 1;
      semi = 0;
      return;
    end
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v = int'(acc) * 10 + int'(c - CH_ZERO);
      acc = (v > int'(PARAM_MAX)) ? PARAM_MAX : v[15:0];
      digits_open = 1;
      started = 1;
      semi = 0;
      return;
    end
    if (c == CH_SEMI || c == CH_COLON) begin
      push_param(digits_open ? acc : 16'd0);
      acc = '0;
      digits_open = 0;
      started = 1;
      semi = (c == CH_SEMI);
      return;
    end
    if (c >= CH_SPACE && c <= CH_QMARK) begin
      started = 1;
      semi = 0;
      return;
    end
    if (digits_open) begin
      push_param(acc);
    end else if (semi) begin
      push_param(16'd0);
    end
    if (!priv) begin
      p = arg(0, 1);
      case (c)
        FIN_CUU: queue_cmd(OP_MOVE, -p, 0, 0, 1'b0);
        FIN_CUD: queue_cmd(OP_MOVE, p, 0, 0, 1'b0);
        FIN_CUF: queue_cmd(OP_MOVE, 0, p, 0, 1'b0);
        FIN_CUB: queue_cmd(OP_MOVE, 0, -p, 0, 1'b0);
        FIN_CNL: queue_cmd(OP_MOVE, p, 0, 0, 1'b1);
        FIN_CPL: queue_cmd(OP_MOVE, -p, 0, 0, 1'b1);
        FIN_CHA: queue_cmd(OP_SET_COL, 0, p - 1, 0, 1'b0);
        FIN_CUP, FIN_HVP: queue_cmd(OP_SET_POS, p - 1, arg(1, 1) - 1, 0, 1'b0);
        FIN_ED: queue_cmd(OP_ERASE_DISP, 0, 0, (count != 0) ? int'(first_p) : 0, 1'b0);
        FIN_EL: queue_cmd(OP_ERASE_LINE, 0, 0, (count != 0) ? int'(first_p) : 0, 1'b0);
        FIN_SU: queue_cmd(OP_SCROLL_UP, 0, 0, p, 1'b0);
        FIN_SD: queue_cmd(OP_SCROLL_DN, 0, 0, p, 1'b0);
        FIN_VPA: queue_cmd(OP_SET_ROW, p - 1, 0, 0, 1'b0);
        FIN_STBM: begin
          if (count == 2'd0) begin
            queue_cmd(OP_RST_REGION, 0, 0, 0, 1'b0);
          end else begin
            queue_cmd(OP_SET_REGION, p - 1, arg(1, int'(rows)) - 1, 0, 1'b0);
          end
        end
        FIN_SCP: queue_cmd(OP_SAVE, 0, 0, 0, 1'b0);
        FIN_RCP: queue_cmd(OP_RESTORE, 0, 0, 0, 1'b0);
        default: ;
      endcase
    end
    clear_seq();
  endfunction

  task report(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    errors++;
  endtask

  task check_command(logic [55:0] word);
    csi_result_t got;
    csi_result_t want;
    got = word[54:0];
    if (pending_cmds.size() == 0) begin
      report($sformatf("unexpected command word %h", word));
      return;
    end
    want = pending_cmds.pop_front();
    cmds_checked++;
    ops_seen[want.op] = 1'b1;
    if (got.op !== want.op)
      report($sformatf("op got %0d want %0d", got.op, want.op));
    if (got.row_value !== want.row_value)
      report($sformatf("row_value got %0d want %0d", got.row_value, want.row_value));
    if (got.col_value !== want.col_value)
      report($sformatf("col_value got %0d want %0d", got.col_value, want.col_value));
    if (got.amount !== want.amount)
      report($sformatf("amount got %0d want %0d", got.amount, want.amount));
    if (got.col_home !== want.col_home)
      report($sformatf("col_home got %b want %b",
                       got.col_home, want.col_home));
    if (word[55] !== 1'b0)
      report("pad bit 55 set");
  endtask
endclass

module tb_csi_sequence_decoder;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 150;

  localparam logic [7:0] FIN_IL  = 8'h4C;
  localparam logic [7:0] FIN_DL  = 8'h4D;
  localparam logic [7:0] FIN_SGR = 8'h6D;
  localparam logic [7:0] FIN_DSR = 8'h6E;
  localparam logic [7:0] CH_SKIP_HI = 8'h2F;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;

  logic [7:0] known_fins[17] = '{FIN_CUU, FIN_CUD, FIN_CUF, FIN_CUB, FIN_CNL, FIN_CPL,
                                 FIN_CHA, FIN_CUP, FIN_ED, FIN_EL, FIN_SU, FIN_SD,
                                 FIN_VPA, FIN_HVP, FIN_STBM, FIN_SCP, FIN_RCP};
  logic [7:0] markers[4] = '{CH_QMARK, CH_GT, CH_EQ, CH_BANG};

  command_scoreboard sb;
  int bytes_sent;
  int hold_len;
  bit tx_idle;
  bit rx_idle;
  logic [15:0] rand_rows;

  csi_sequence_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        m_tready <= 1'b0;
        repeat (hold_len - 1) @(negedge clk);
        hold_len = 0;
      end else if (rx_idle && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(0, 2)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_command(m_tdata);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Watchdog: no handshake for %0d cycles", QUIET_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_byte(input logic [7:0] b);
    if (tx_idle && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    sb.note_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_byte(s[i]);
  endtask

  function automatic int param_value();
    case ($urandom_range(0, 9))
      0: return $urandom_range(65536, 999999);
      1: return $urandom_range(1000, 65535);
      2: return 0;
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  function automatic logic [7:0] pick_final(input bit cmd_only);
    if (cmd_only || $urandom_range(0, 6) != 0) begin
      return known_fins[$urandom_range(0, 16)];
    end
    case ($urandom_range(0, 5))
      0: return FIN_IL;
      1: return FIN_DL;
      2: return FIN_SGR;
      3: return FIN_DSR;
      4: return 8'($urandom_range(0, 8'h1F));
      default: return 8'($urandom_range(8'h80, 8'hFF));
    endcase
  endfunction

  task automatic send_sequence(input bit cmd_only);
    logic [7:0] seq[$];
    string digits;
    int n;
    if (!cmd_only && $urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      return;
    end
    if (!cmd_only && $urandom_range(0, 9) == 0) begin
      seq = {seq, markers[$urandom_range(0, 3)]};
    end
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 5) != 0) begin
        digits = $sformatf("%0d", param_value());
        if ($urandom_range(0, 7) == 0) digits = {"0", digits};
        foreach (digits[j]) begin
          seq = {seq, digits[j]};
          if ($urandom_range(0, 15) == 0) begin
            seq = {seq, 8'($urandom_range(CH_SPACE, CH_SKIP_HI))};
          end
        end
      end
      if (i < n - 1 || $urandom_range(0, 4) == 0) begin
        seq = {seq, (($urandom_range(0, 3) == 0) ? CH_COLON : CH_SEMI)};
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      seq = {seq, 8'($urandom_range(CH_SPACE, CH_SKIP_HI))};
    end
    seq = {seq, pick_final(cmd_only)};
    foreach (seq[k]) send_byte(seq[k]);
  endtask

  task automatic run_random(input int target);
    while (bytes_sent < target) send_sequence(1'b0);
  endtask

  // Drain the pipeline, then write screen_rows.
  task automatic set_rows(input logic [15:0] v);
    s_tvalid <= 1'b0;
    while (sb.pending_cmds.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.rows = v;
  endtask

  initial begin : stimulus
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    hold_len = 0;
    bytes_sent = 0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    sb = new();
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_text("?5h");
    send_text("99999;;A");
    send_text("3:r");
    send_text("1?2G");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("sur;H");

    set_rows(16'd1);
    run_random(200);

    set_rows(16'hFFFF);
    tx_idle = 1'b0;
    hold_len = HOLD_CYCLES;
    repeat (40) send_sequence(1'b1);
    tx_idle = 1'b1;
    run_random(380);

    set_rows(16'd0);
    send_text("5r");
    run_random(540);

    rand_rows = 16'($urandom_range(2, 65534));
    set_rows(rand_rows);
    run_random(700);

    set_rows(16'd80);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    run_random(900);

    s_tvalid <= 1'b0;
    while (sb.pending_cmds.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Run covered %0d sequence bytes and %0d command words, %0d of 12 command kinds.",
             bytes_sent, sb.cmds_checked, $countones(sb.ops_seen));
    $display("screen_rows took 24, 1, 65535, 0, %0d and 80; output held off %0d cycles once.",
             rand_rows, HOLD_CYCLES);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
